// ===== hw/rtl/isse_pkg.sv =====
`default_nettype none
package isse_pkg;

  // built matrix order unless the top level is told otherwise
  localparam int DEF_MAX_ORDER = 16;

  // index compares are done at this width (covers any order up to 255 and the 5-bit order reg)
  localparam int CMP_W = 8;

  localparam int VAL_W   = 24;
  localparam int MASS_W  = 28;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 56;
  localparam int DACC_W  = 58;
  localparam int NV_W    = 41;
  localparam int Z_W     = 7;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_REBUILD = 3'd1;
  localparam logic [2:0] CMD_EVAL    = 3'd2;
  localparam logic [2:0] CMD_COMMIT  = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INFEAS  = 2'd1;
  localparam logic [1:0] STS_NOPEND  = 2'd2;

  localparam logic [0:0] REG_ORDER = 1'b0;
  localparam logic [0:0] REG_LIMIT = 1'b1;

  localparam logic [4:0]  ORDER_RST = 5'd16;
  localparam logic [22:0] LIMIT_RST = 23'd8388607;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WR_A, S_WR_B,
    S_RB_ROW, S_RB_RD, S_RB_ACC,
    S_EV_RDT, S_EV_RDP, S_EV_MUL, S_EV_ADD, S_EV_SQN, S_EV_SQO, S_EV_ACC,
    S_DG_RD0, S_DG_RD1, S_DG_RD2, S_DG_SS, S_DG_SSP, S_DG_FIN,
    S_CM_RD, S_CM_W1, S_CM_W2, S_CM_DG, S_CM_DW,
    S_RD_RD, S_RD_FIN,
    S_OUT
  } st_t;

  // magnitude of a stored entry, most negative value maps to 2^23
  function automatic logic [VAL_W-1:0] abs24(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    r = v[VAL_W-1] ? (~v + 24'd1) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/isse_ram.sv =====
`default_nettype none
module isse_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/isse_mul.sv =====
`default_nettype none
module isse_mul
  import isse_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic signed [MUL_B_W-1:0] b,
  output logic      signed [PROD_W-1:0]  prod
);

  logic signed [PROD_W-1:0] prod_r;

  // one signed product a cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ===== hw/rtl/integer_symmetric_shear_engine.sv =====
`default_nettype none
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   command, indices, entry value, shear factor
// out      output     out_valid / out_stall status, read value, row mass, deltas
// cfg      input      cfg_we                cfg_index selects order or limit, cfg_wdata
//
// one transaction at a time; in_stall stays high from acceptance until the result
// has been moved into the output register. transaction time is set by the single
// read port of the matrix memory and the shared 32x24 multiplier.
// rst_n is synchronous; it clears the sequencer, the order and limit registers, the
// pending flag, the mass valid bits and the output valid flag. out_stall holds the
// output register, and a new result waits in S_OUT until that register is free; a
// new transaction may be taken while a finished result still waits there.
module integer_symmetric_shear_engine
  import isse_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_command,
  input  wire logic [3:0]         in_entry_row,
  input  wire logic [3:0]         in_entry_column,
  input  wire logic signed [23:0] in_entry_value,
  input  wire logic [3:0]         in_pivot_index,
  input  wire logic [3:0]         in_target_index,
  input  wire logic signed [15:0] in_shear_factor,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic signed [23:0]      out_read_value,
  output logic [26:0]             out_row_mass_value,
  output logic signed [56:0]      out_delta_square_norm,
  output logic signed [4:0]       out_delta_nonzero,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [22:0]        cfg_wdata
);

  // row/column index width and a counter wide enough to hold the order itself
  localparam int IW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int KW  = $clog2(MAX_ORDER + 1);
  localparam int MAW = 2 * IW;

  // sequencer and control
  st_t state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] r_r, r_nxt;
  logic [4:0]    order_r, order_nxt;
  logic [22:0]   limit_r, limit_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [IW-1:0] pend_t_r, pend_t_nxt;
  logic [MAX_ORDER-1:0] mval_r, mval_nxt;
  logic          mval_q_r, mval_q_nxt;
  logic          out_valid_r, out_valid_nxt;

  // captured transaction
  logic [2:0]        cmd_r, cmd_nxt;
  logic [IW-1:0]     er_r, er_nxt, ec_r, ec_nxt, pv_r, pv_nxt, tg_r, tg_nxt;
  logic              rok_r, rok_nxt, cok_r, cok_nxt;
  logic signed [23:0] ev_r, ev_nxt;
  logic signed [15:0] sf_r, sf_nxt;

  // datapath
  logic signed [23:0]       old_r, old_nxt, nv_r, nv_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DACC_W-1:0] dacc_r, dacc_nxt;
  logic signed [Z_W-1:0]    z_r, z_nxt;
  logic [MASS_W-1:0]        mt_r, mt_nxt;

  // result staging and output register
  logic [1:0]         res_sts_r, res_sts_nxt, out_sts_r, out_sts_nxt;
  logic signed [23:0] res_rd_r, res_rd_nxt, out_rd_r, out_rd_nxt;
  logic [26:0]        res_rm_r, res_rm_nxt, out_rm_r, out_rm_nxt;
  logic signed [56:0] res_dn_r, res_dn_nxt, out_dn_r, out_dn_nxt;
  logic signed [4:0]  res_dz_r, res_dz_nxt, out_dz_r, out_dz_nxt;

  // memory ports
  logic              m_we, p_we, s_we;
  logic [MAW-1:0]    m_waddr, m_raddr;
  logic [IW-1:0]     p_waddr, p_raddr, s_waddr, s_raddr;
  logic [VAL_W-1:0]  m_wdata, m_rdata, p_wdata, p_rdata;
  logic [MASS_W-1:0] s_wdata, s_rdata;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  isse_ram #(.WIDTH(VAL_W), .DEPTH(1 << MAW)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  isse_ram #(.WIDTH(VAL_W), .DEPTH(1 << IW)) u_pending (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  isse_ram #(.WIDTH(MASS_W), .DEPTH(1 << IW)) u_mass (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  isse_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      order_r      <= ORDER_RST;
      limit_r      <= LIMIT_RST;
      pend_valid_r <= 1'b0;
      pend_t_r     <= '0;
      mval_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      order_r      <= order_nxt;
      limit_r      <= limit_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_t_r     <= pend_t_nxt;
      mval_r       <= mval_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;  r_r <= r_nxt;  mval_q_r <= mval_q_nxt;
    cmd_r <= cmd_nxt; er_r <= er_nxt; ec_r <= ec_nxt; pv_r <= pv_nxt; tg_r <= tg_nxt;
    rok_r <= rok_nxt; cok_r <= cok_nxt; ev_r <= ev_nxt; sf_r <= sf_nxt;
    old_r <= old_nxt; nv_r <= nv_nxt; acc_r <= acc_nxt; dacc_r <= dacc_nxt;
    z_r <= z_nxt; mt_r <= mt_nxt;
    res_sts_r <= res_sts_nxt; res_rd_r <= res_rd_nxt; res_rm_r <= res_rm_nxt;
    res_dn_r <= res_dn_nxt; res_dz_r <= res_dz_nxt;
    out_sts_r <= out_sts_nxt; out_rd_r <= out_rd_nxt; out_rm_r <= out_rm_nxt;
    out_dn_r <= out_dn_nxt; out_dz_r <= out_dz_nxt;
  end

  // effective order, clamped to at least 2 and at most the built size
  logic [CMP_W-1:0] n_c, order_x;
  always_comb begin
    order_x = CMP_W'(order_r);
    if (order_x < CMP_W'(2)) begin
      n_c = CMP_W'(2);
    end else if (order_x > CMP_W'(MAX_ORDER)) begin
      n_c = CMP_W'(MAX_ORDER);
    end else begin
      n_c = order_x;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    logic [CMP_W-1:0]         er_x, ec_x, pv_x, tg_x;
    logic [IW-1:0]            k_i, r_i;
    logic                     k_end;
    logic signed [NV_W-1:0]   nv41, lim41;
    logic signed [DACC_W-1:0] ntt, lim58;
    logic [MASS_W-1:0]        ms_eff;

    state_nxt = state_r;  k_nxt = k_r;  r_nxt = r_r;
    order_nxt = order_r;  limit_nxt = limit_r;
    pend_valid_nxt = pend_valid_r;  pend_t_nxt = pend_t_r;
    mval_nxt = mval_r;  out_valid_nxt = out_valid_r;
    cmd_nxt = cmd_r; er_nxt = er_r; ec_nxt = ec_r; pv_nxt = pv_r; tg_nxt = tg_r;
    rok_nxt = rok_r; cok_nxt = cok_r; ev_nxt = ev_r; sf_nxt = sf_r;
    old_nxt = old_r; nv_nxt = nv_r; acc_nxt = acc_r; dacc_nxt = dacc_r;
    z_nxt = z_r; mt_nxt = mt_r;
    res_sts_nxt = res_sts_r; res_rd_nxt = res_rd_r; res_rm_nxt = res_rm_r;
    res_dn_nxt = res_dn_r; res_dz_nxt = res_dz_r;
    out_sts_nxt = out_sts_r; out_rd_nxt = out_rd_r; out_rm_nxt = out_rm_r;
    out_dn_nxt = out_dn_r; out_dz_nxt = out_dz_r;
    m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    mul_a = '0; mul_b = '0;

    er_x = CMP_W'(in_entry_row);
    ec_x = CMP_W'(in_entry_column);
    pv_x = CMP_W'(in_pivot_index);
    tg_x = CMP_W'(in_target_index);
    k_i  = k_r[IW-1:0];
    r_i  = r_r[IW-1:0];
    k_end = (CMP_W'(k_r) == n_c);
    nv41  = NV_W'(old_r) + $signed(prod[NV_W-1:0]);
    lim41 = $signed({{(NV_W-23){1'b0}}, limit_r});
    ntt   = dacc_r + DACC_W'(prod);
    lim58 = $signed({{(DACC_W-23){1'b0}}, limit_r});
    // mass rows never written since reset read as zero
    ms_eff = mval_q_r ? s_rdata : '0;

    // output register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_ORDER: begin
          order_nxt      = cfg_wdata[4:0];
          pend_valid_nxt = 1'b0;
        end
        REG_LIMIT: limit_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_command;
          er_nxt  = er_x[IW-1:0];
          ec_nxt  = ec_x[IW-1:0];
          pv_nxt  = pv_x[IW-1:0];
          tg_nxt  = tg_x[IW-1:0];
          rok_nxt = (er_x < n_c);
          cok_nxt = (ec_x < n_c);
          ev_nxt  = in_entry_value;
          sf_nxt  = in_shear_factor;
          k_nxt   = '0;
          r_nxt   = '0;
          acc_nxt = '0;
          z_nxt   = '0;
          mt_nxt  = '0;
          res_sts_nxt = STS_OK;
          res_rd_nxt  = '0;
          res_rm_nxt  = '0;
          res_dn_nxt  = '0;
          res_dz_nxt  = '0;
          state_nxt   = S_OUT;
          case (in_command)
            CMD_WRITE: begin
              if ((er_x < n_c) && (ec_x < n_c)) state_nxt = S_WR_A;
            end
            CMD_REBUILD: state_nxt = S_RB_ROW;
            CMD_EVAL: begin
              if ((pv_x < n_c) && (tg_x < n_c)) begin
                state_nxt = S_EV_RDT;
              end else begin
                res_sts_nxt    = STS_INFEAS;
                pend_valid_nxt = 1'b0;
              end
            end
            CMD_COMMIT: begin
              if (pend_valid_r && (CMP_W'(pend_t_r) < n_c)) begin
                state_nxt = S_CM_RD;
              end else begin
                res_sts_nxt    = STS_NOPEND;
                pend_valid_nxt = 1'b0;
              end
            end
            CMD_READ: state_nxt = S_RD_RD;
            default: ;
          endcase
        end
      end

      // entry and its mirror, one write port
      S_WR_A: begin
        m_we = 1'b1; m_waddr = {er_r, ec_r}; m_wdata = ev_r;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        m_we = 1'b1; m_waddr = {ec_r, er_r}; m_wdata = ev_r;
        state_nxt = S_OUT;
      end

      // rebuild: every built row, rows beyond the order get zero
      S_RB_ROW: begin
        if (r_r == KW'(MAX_ORDER)) begin
          state_nxt = S_OUT;
        end else if (CMP_W'(r_r) >= n_c) begin
          s_we = 1'b1; s_waddr = r_i; s_wdata = '0;
          mval_nxt[r_i] = 1'b1;
          r_nxt = r_r + KW'(1);
        end else begin
          k_nxt = '0;
          mt_nxt = '0;
          state_nxt = S_RB_RD;
        end
      end
      S_RB_RD: begin
        if (k_end) begin
          s_we = 1'b1; s_waddr = r_i; s_wdata = mt_r;
          mval_nxt[r_i] = 1'b1;
          r_nxt = r_r + KW'(1);
          state_nxt = S_RB_ROW;
        end else if (k_r == r_r) begin
          k_nxt = k_r + KW'(1);
        end else begin
          m_raddr = {r_i, k_i};
          k_nxt = k_r + KW'(1);
          state_nxt = S_RB_ACC;
        end
      end
      S_RB_ACC: begin
        mt_nxt = mt_r + MASS_W'(abs24(m_rdata));
        state_nxt = S_RB_RD;
      end

      // evaluate: one off-diagonal column of the target row per pass
      S_EV_RDT: begin
        if (k_end) begin
          state_nxt = S_DG_RD0;
        end else if (k_i == tg_r) begin
          k_nxt = k_r + KW'(1);
        end else begin
          m_raddr = {tg_r, k_i};
          state_nxt = S_EV_RDP;
        end
      end
      S_EV_RDP: begin
        m_raddr = {pv_r, k_i};
        old_nxt = $signed(m_rdata);
        state_nxt = S_EV_MUL;
      end
      S_EV_MUL: begin
        mul_a = MUL_A_W'(sf_r);
        mul_b = $signed(m_rdata);
        state_nxt = S_EV_ADD;
      end
      S_EV_ADD: begin
        if ((nv41 > lim41) || (nv41 < -lim41)) begin
          res_sts_nxt    = STS_INFEAS;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_OUT;
        end else begin
          nv_nxt = nv41[23:0];
          p_we = 1'b1; p_waddr = k_i; p_wdata = nv41[23:0];
          if ((old_r == 24'sd0) && (nv41 != '0)) begin
            z_nxt = z_r + Z_W'(1);
          end else if ((old_r != 24'sd0) && (nv41 == '0)) begin
            z_nxt = z_r - Z_W'(1);
          end
          state_nxt = S_EV_SQN;
        end
      end
      S_EV_SQN: begin
        mul_a = MUL_A_W'(nv_r);
        mul_b = nv_r;
        state_nxt = S_EV_SQO;
      end
      S_EV_SQO: begin
        mul_a = MUL_A_W'(old_r);
        mul_b = old_r;
        acc_nxt = acc_r + prod[ACC_W-1:0];
        state_nxt = S_EV_ACC;
      end
      S_EV_ACC: begin
        acc_nxt = acc_r - prod[ACC_W-1:0];
        k_nxt = k_r + KW'(1);
        state_nxt = S_EV_RDT;
      end

      // diagonal: t,t + 2*s*t,p + s*s*p,p
      S_DG_RD0: begin
        m_raddr = {tg_r, tg_r};
        state_nxt = S_DG_RD1;
      end
      S_DG_RD1: begin
        m_raddr = {tg_r, pv_r};
        dacc_nxt = DACC_W'($signed(m_rdata));
        state_nxt = S_DG_RD2;
      end
      S_DG_RD2: begin
        m_raddr = {pv_r, pv_r};
        mul_a = MUL_A_W'(sf_r);
        mul_b = $signed(m_rdata);
        state_nxt = S_DG_SS;
      end
      S_DG_SS: begin
        old_nxt = $signed(m_rdata);
        mul_a = MUL_A_W'(sf_r);
        mul_b = MUL_B_W'(sf_r);
        dacc_nxt = dacc_r + DACC_W'($signed({prod, 1'b0}));
        state_nxt = S_DG_SSP;
      end
      S_DG_SSP: begin
        mul_a = $signed(prod[MUL_A_W-1:0]);
        mul_b = old_r;
        state_nxt = S_DG_FIN;
      end
      S_DG_FIN: begin
        if ((ntt > lim58) || (ntt < -lim58)) begin
          res_sts_nxt    = STS_INFEAS;
          pend_valid_nxt = 1'b0;
        end else begin
          p_we = 1'b1; p_waddr = tg_r; p_wdata = ntt[23:0];
          pend_valid_nxt = 1'b1;
          pend_t_nxt     = tg_r;
          res_dn_nxt     = $signed({acc_r, 1'b0});
          if (z_r > Z_W'(15)) begin
            res_dz_nxt = 5'sd15;
          end else if (z_r < -Z_W'(15)) begin
            res_dz_nxt = -5'sd15;
          end else begin
            res_dz_nxt = z_r[4:0];
          end
        end
        state_nxt = S_OUT;
      end

      // commit: row and mirror column, masses adjusted on the way
      S_CM_RD: begin
        if (k_end) begin
          state_nxt = S_CM_DG;
        end else if (k_i == pend_t_r) begin
          k_nxt = k_r + KW'(1);
        end else begin
          m_raddr = {pend_t_r, k_i};
          p_raddr = k_i;
          state_nxt = S_CM_W1;
        end
      end
      S_CM_W1: begin
        old_nxt = $signed(m_rdata);
        nv_nxt  = $signed(p_rdata);
        m_we = 1'b1; m_waddr = {pend_t_r, k_i}; m_wdata = p_rdata;
        s_raddr = k_i;
        mt_nxt = mt_r + MASS_W'(abs24(p_rdata));
        state_nxt = S_CM_W2;
      end
      S_CM_W2: begin
        m_we = 1'b1; m_waddr = {k_i, pend_t_r}; m_wdata = nv_r;
        s_we = 1'b1; s_waddr = k_i;
        s_wdata = ms_eff + MASS_W'(abs24(nv_r)) - MASS_W'(abs24(old_r));
        mval_nxt[k_i] = 1'b1;
        k_nxt = k_r + KW'(1);
        state_nxt = S_CM_RD;
      end
      S_CM_DG: begin
        p_raddr = pend_t_r;
        state_nxt = S_CM_DW;
      end
      S_CM_DW: begin
        m_we = 1'b1; m_waddr = {pend_t_r, pend_t_r}; m_wdata = p_rdata;
        s_we = 1'b1; s_waddr = pend_t_r; s_wdata = mt_r;
        mval_nxt[pend_t_r] = 1'b1;
        pend_valid_nxt = 1'b0;
        state_nxt = S_OUT;
      end

      S_RD_RD: begin
        m_raddr = {er_r, ec_r};
        s_raddr = er_r;
        state_nxt = S_RD_FIN;
      end
      S_RD_FIN: begin
        res_rd_nxt = (rok_r && cok_r) ? $signed(m_rdata) : 24'sd0;
        if (rok_r && !ms_eff[MASS_W-1]) begin
          res_rm_nxt = ms_eff[26:0];
        end else begin
          res_rm_nxt = '0;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_sts_nxt   = res_sts_r;
          out_rd_nxt    = res_rd_r;
          out_rm_nxt    = res_rm_r;
          out_dn_nxt    = res_dn_r;
          out_dz_nxt    = res_dz_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    mval_q_nxt = mval_r[s_raddr];
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_sts_r;
  assign out_read_value        = out_rd_r;
  assign out_row_mass_value    = out_rm_r;
  assign out_delta_square_norm = out_dn_r;
  assign out_delta_nonzero     = out_dz_r;

endmodule
`default_nettype wire
